/* hdl/j2g_pkg.sv */
// shared types and constants for the j2 gravity vector core
// no dependencies; imported by the cells, multipliers, post-processing, top level and testbench
package j2g_pkg;

  localparam int CordicSteps = 32;
  localparam int CellCount   = 62;

  localparam logic signed [33:0] CordicX0 = 34'sd652032874;
  localparam logic [63:0]        Lim61    = 64'h2000_0000_0000_0000;
  localparam logic signed [63:0] OneQ30   = 64'sd1073741824;

  typedef enum logic [1:0] {
    REG_EARTH_RATE,
    REG_GRAV_PARAM,
    REG_EQ_RADIUS,
    REG_J2_COEF
  } reg_idx_t;

  localparam logic [29:0] AtanTab [CordicSteps] = '{
    30'h20000000, 30'h12E4051E, 30'h09FB385B, 30'h051111D4, 30'h028B0D43, 30'h0145D7E1,
    30'h00A2F61E, 30'h00517C55, 30'h0028BE53, 30'h00145F2F, 30'h000A2F98, 30'h000517CC,
    30'h00028BE6, 30'h000145F3, 30'h0000A2FA, 30'h0000517D, 30'h000028BE, 30'h0000145F,
    30'h00000A30, 30'h00000518, 30'h0000028C, 30'h00000146, 30'h000000A3, 30'h00000051,
    30'h00000029, 30'h00000014, 30'h0000000A, 30'h00000005, 30'h00000003, 30'h00000001,
    30'h00000001, 30'h00000000
  };

  // one rotator: vector, residual angle, half-turn flag
  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] z;
    logic               flip;
  } rot_t;

  // state handed from cell to cell
  typedef struct packed {
    rot_t        lat;
    rot_t        lon;
    logic [63:0] r2;
    logic [65:0] num_t;
    logic [79:0] num_e;
    logic [63:0] rem_t;
    logic [63:0] rem_e;
    logic [61:0] quo_t;
    logic [61:0] quo_e;
    logic        sat_t;
    logic        sat_e;
    logic        zero;
  } cell_t;

  typedef struct packed {
    logic               zero;
    logic signed [63:0] t;
    logic signed [63:0] s;
    logic signed [63:0] c;
    logic signed [63:0] so;
    logic signed [63:0] co;
  } side_t;

endpackage

/* hdl/j2g_in_if.sv */
// input channel: position, angles and time with valid/ready
// no dependencies
interface j2g_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [31:0] latitude;
  logic signed [31:0] longitude;
  logic [47:0]        sim_time;

  modport source (output valid, pos_x, pos_y, pos_z, latitude, longitude, sim_time,
                  input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, latitude, longitude, sim_time,
                output ready);
endinterface

/* hdl/j2g_out_if.sv */
// output channel: gravity vector with valid/ready
// no dependencies
interface j2g_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] grav_x;
  logic signed [31:0] grav_y;
  logic signed [31:0] grav_z;

  modport source (output valid, grav_x, grav_y, grav_z, input ready);
  modport sink (input valid, grav_x, grav_y, grav_z, output ready);
endinterface

/* hdl/j2g_cell.sv */
// one cell of the chain: a quotient bit for both divisions and, while stage is below
// CordicSteps, one cordic step for both angles; depends on j2g_pkg
module j2g_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic [5:0]     stage,
  input  logic           valid_in,
  input  j2g_pkg::cell_t d,
  output logic           valid_out,
  output j2g_pkg::cell_t q
);
  import j2g_pkg::*;

  function automatic rot_t rot_step(rot_t r, logic [4:0] sh, logic [29:0] a);
    logic signed [33:0] dx;
    logic signed [33:0] dy;
    logic signed [33:0] at;
    rot_t               o;
    dx = r.y >>> sh;
    dy = r.x >>> sh;
    at = {4'b0000, a};
    o  = r;
    if (!r.z[33]) begin
      o.x = r.x - dx;
      o.y = r.y + dy;
      o.z = r.z - at;
    end else begin
      o.x = r.x + dx;
      o.y = r.y - dy;
      o.z = r.z + at;
    end
    return o;
  endfunction

  cell_t       nxt;
  logic [5:0]  bit_idx;
  logic [64:0] tr_t;
  logic [64:0] tr_e;
  logic [29:0] atan;

  always_comb begin
    nxt     = d;
    bit_idx = 6'd61 - stage;
    atan    = AtanTab[stage[4:0]];
    if (stage < 6'(CordicSteps)) begin
      nxt.lat = rot_step(d.lat, stage[4:0], atan);
      nxt.lon = rot_step(d.lon, stage[4:0], atan);
    end
    // restoring division, next dividend bit shifted in
    tr_t = {d.rem_t, d.num_t[{1'b0, bit_idx}]};
    tr_e = {d.rem_e, d.num_e[{1'b0, bit_idx}]};
    if (tr_t >= {1'b0, d.r2}) begin
      nxt.rem_t = 64'(tr_t - {1'b0, d.r2});
      nxt.quo_t = {d.quo_t[60:0], 1'b1};
    end else begin
      nxt.rem_t = tr_t[63:0];
      nxt.quo_t = {d.quo_t[60:0], 1'b0};
    end
    if (tr_e >= {1'b0, d.r2}) begin
      nxt.rem_e = 64'(tr_e - {1'b0, d.r2});
      nxt.quo_e = {d.quo_e[60:0], 1'b1};
    end else begin
      nxt.rem_e = tr_e[63:0];
      nxt.quo_e = {d.quo_e[60:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (en) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= nxt;
    end
  end

endmodule

/* hdl/j2g_mulsh.sv */
// two-stage signed multiply, shift right toward zero, magnitude limited to 2^61
// built from four 32x32 partial products; depends on j2g_pkg
module j2g_mulsh (
  input  logic               clk,
  input  logic               en,
  input  logic [5:0]         sh,
  input  logic signed [63:0] a,
  input  logic signed [63:0] b,
  output logic signed [63:0] p
);
  import j2g_pkg::*;

  logic [63:0]  ua;
  logic [63:0]  ub;
  logic [63:0]  p00;
  logic [63:0]  p01;
  logic [63:0]  p10;
  logic [63:0]  p11;
  logic         neg;
  logic [127:0] full;
  logic [127:0] shifted;
  logic [63:0]  mag;

  always_comb begin
    ua = a[63] ? (64'd0 - a) : a;
    ub = b[63] ? (64'd0 - b) : b;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p00 <= ua[31:0] * ub[31:0];
      p01 <= ua[31:0] * ub[63:32];
      p10 <= ua[63:32] * ub[31:0];
      p11 <= ua[63:32] * ub[63:32];
      neg <= a[63] ^ b[63];
    end
  end

  always_comb begin
    full = {64'd0, p00} + {32'd0, p01, 32'd0} + {32'd0, p10, 32'd0} + {p11, 64'd0};
    shifted = full >> sh;
    mag = (shifted > {64'd0, Lim61}) ? Lim61 : shifted[63:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p <= neg ? (64'sd0 - $signed(mag)) : $signed(mag);
    end
  end

endmodule

/* hdl/j2g_post.sv */
// product network after the cell chain: j2 terms, north/down terms, axis mapping
// and saturation; depends on j2g_pkg and j2g_mulsh
module j2g_post (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               valid_in,
  input  j2g_pkg::cell_t     d,
  input  logic [23:0]        j2_coefficient,
  output logic               valid_out,
  output logic signed [31:0] grav_x,
  output logic signed [31:0] grav_y,
  output logic signed [31:0] grav_z
);
  import j2g_pkg::*;

  function automatic logic signed [31:0] sat32(logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  side_t              side_in;
  side_t              sd [0:9];
  logic               v [0:9];
  logic signed [63:0] e_in;
  logic signed [63:0] p_q, sc_q, s2_q, n_q, dm_q, gn_q, gd_q;
  logic signed [63:0] a1_q, a2_q, b1_q, b2_q, c1_q, c2_q;
  logic signed [63:0] b1s_q, b2c_q, c1s_q, c2c_q;
  logic signed [63:0] n_a, d_t, d_a, gx0, gx1, gy, gz;

  always_comb begin
    side_in.zero = d.zero;
    side_in.s  = d.lat.flip ? -64'(d.lat.y) : 64'(d.lat.y);
    side_in.c  = d.lat.flip ? -64'(d.lat.x) : 64'(d.lat.x);
    side_in.so = d.lon.flip ? -64'(d.lon.y) : 64'(d.lon.y);
    side_in.co = d.lon.flip ? -64'(d.lon.x) : 64'(d.lon.x);
    side_in.t  = (d.sat_t || {2'b00, d.quo_t} > Lim61) ? Lim61 : {2'b00, d.quo_t};
    e_in       = (d.sat_e || {2'b00, d.quo_e} > Lim61) ? Lim61 : {2'b00, d.quo_e};
  end

  // level 1: P, SC, S2
  j2g_mulsh u_p  (.clk, .en, .sh(6'd32), .a({40'd0, j2_coefficient}), .b(e_in), .p(p_q));
  j2g_mulsh u_sc (.clk, .en, .sh(6'd30), .a(side_in.s), .b(side_in.c), .p(sc_q));
  j2g_mulsh u_s2 (.clk, .en, .sh(6'd30), .a(side_in.s), .b(side_in.s), .p(s2_q));

  always_comb begin
    n_a = 64'sd0 - (sc_q + (sc_q <<< 1));
    d_t = OneQ30 - (s2_q + (s2_q <<< 1));
    d_a = d_t + (d_t <<< 1);
  end

  // level 2: N and the j2 part of D
  j2g_mulsh u_n  (.clk, .en, .sh(6'd32), .a(n_a), .b(p_q), .p(n_q));
  j2g_mulsh u_dm (.clk, .en, .sh(6'd33), .a(d_a), .b(p_q), .p(dm_q));

  // level 3: north and down terms
  j2g_mulsh u_gn (.clk, .en, .sh(6'd30), .a(sd[3].t), .b(n_q), .p(gn_q));
  j2g_mulsh u_gd (.clk, .en, .sh(6'd30), .a(sd[3].t), .b(OneQ30 + dm_q), .p(gd_q));

  // level 4: first factor of each axis product
  j2g_mulsh u_a1 (.clk, .en, .sh(6'd30), .a(gn_q), .b(sd[5].c), .p(a1_q));
  j2g_mulsh u_a2 (.clk, .en, .sh(6'd30), .a(gd_q), .b(sd[5].s), .p(a2_q));
  j2g_mulsh u_b1 (.clk, .en, .sh(6'd30), .a(gn_q), .b(sd[5].so), .p(b1_q));
  j2g_mulsh u_b2 (.clk, .en, .sh(6'd30), .a(gd_q), .b(sd[5].so), .p(b2_q));
  j2g_mulsh u_c1 (.clk, .en, .sh(6'd30), .a(gn_q), .b(sd[5].co), .p(c1_q));
  j2g_mulsh u_c2 (.clk, .en, .sh(6'd30), .a(gd_q), .b(sd[5].co), .p(c2_q));

  // level 5: second factor for y and z
  j2g_mulsh u_b1s (.clk, .en, .sh(6'd30), .a(b1_q), .b(sd[7].s), .p(b1s_q));
  j2g_mulsh u_b2c (.clk, .en, .sh(6'd30), .a(b2_q), .b(sd[7].c), .p(b2c_q));
  j2g_mulsh u_c1s (.clk, .en, .sh(6'd30), .a(c1_q), .b(sd[7].s), .p(c1s_q));
  j2g_mulsh u_c2c (.clk, .en, .sh(6'd30), .a(c2_q), .b(sd[7].c), .p(c2c_q));

  always_comb begin
    gy = 64'sd0 - b1s_q - b2c_q;
    gz = c1s_q + c2c_q;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd[0] <= side_in;
      for (int i = 1; i < 10; i++) begin
        sd[i] <= sd[i-1];
      end
      gx0 <= a1_q - a2_q;
      gx1 <= gx0;
      grav_x <= sd[9].zero ? 32'sd0 : sat32(gx1);
      grav_y <= sd[9].zero ? 32'sd0 : sat32(gy);
      grav_z <= sd[9].zero ? 32'sd0 : sat32(gz);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 10; i++) begin
        v[i] <= 1'b0;
      end
      valid_out <= 1'b0;
    end else if (en) begin
      v[0] <= valid_in;
      for (int i = 1; i < 10; i++) begin
        v[i] <= v[i-1];
      end
      valid_out <= v[9];
    end
  end

endmodule

/* hdl/j2_gravity_vector_core.sv */
// j2 gravity vector core: throughput one item per cycle; the chain of 62 cells
// (one quotient bit each, one rotation step in each of the first CordicSteps cells) and
// the product network all advance together, holding while a finished result waits on
// the output; reset clears all valid bits and loads the register defaults; depends on
// j2g_pkg, j2g_in_if, j2g_out_if, j2g_cell, j2g_post
module j2_gravity_vector_core (
  input  logic        clk,
  input  logic        rst,
  j2g_in_if.sink      in_ch,
  j2g_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import j2g_pkg::*;

  logic [31:0] earth_rate;
  logic [49:0] grav_parameter;
  logic [23:0] eq_radius;
  logic [23:0] j2_coefficient;

  logic        en;
  logic        f1_v, f2_v, f3_v;
  logic [31:0] ax, ay, az, f1_lat, f1_lon;
  logic [63:0] pa;
  logic [47:0] pb;
  logic [63:0] sx, sy, sz;
  logic [31:0] f2_lat, f2_lon, f3_lat, f3_lon;
  logic [47:0] f2_re2, f3_re2;
  logic [63:0] r2;
  cell_t       ch [0:CellCount];
  logic        chv [0:CellCount];
  logic        out_v;

  function automatic rot_t rot_init(logic [31:0] ang);
    rot_t r;
    r.flip = ang[31] ^ ang[30];
    r.z    = r.flip ? 34'($signed({~ang[31], ang[30:0]})) : 34'($signed(ang));
    r.x    = CordicX0;
    r.y    = 34'sd0;
    return r;
  endfunction

  // configuration port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      earth_rate     <= 32'd49846;
      grav_parameter <= 50'd398600441800000;
      eq_radius      <= 24'd6378137;
      j2_coefficient <= 24'd4649860;
    end else if (psel && penable && pwrite) begin
      case (reg_idx_t'(paddr[4:3]))
        REG_EARTH_RATE: earth_rate     <= pwdata[31:0];
        REG_GRAV_PARAM: grav_parameter <= pwdata[49:0];
        REG_EQ_RADIUS:  eq_radius      <= pwdata[23:0];
        REG_J2_COEF:    j2_coefficient <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[4:3]))
      REG_EARTH_RATE: prdata = {32'd0, earth_rate};
      REG_GRAV_PARAM: prdata = {14'd0, grav_parameter};
      REG_EQ_RADIUS:  prdata = {40'd0, eq_radius};
      REG_J2_COEF:    prdata = {40'd0, j2_coefficient};
      default:        prdata = 64'd0;
    endcase
  end

  // whole pipeline advances unless a result is held on the output
  assign en          = !out_v || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_v <= 1'b0;
      f2_v <= 1'b0;
      f3_v <= 1'b0;
    end else if (en) begin
      f1_v <= in_ch.valid;
      f2_v <= f1_v;
      f3_v <= f2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax     <= in_ch.pos_x[31] ? (32'd0 - in_ch.pos_x) : in_ch.pos_x;
      ay     <= in_ch.pos_y[31] ? (32'd0 - in_ch.pos_y) : in_ch.pos_y;
      az     <= in_ch.pos_z[31] ? (32'd0 - in_ch.pos_z) : in_ch.pos_z;
      pa     <= earth_rate * in_ch.sim_time[31:0];
      pb     <= earth_rate * in_ch.sim_time[47:32];
      f1_lat <= in_ch.latitude;
      f1_lon <= in_ch.longitude;

      sx     <= ax * ax;
      sy     <= ay * ay;
      sz     <= az * az;
      f2_lat <= f1_lat;
      // earth rotation phase, 32-bit wrap
      f2_lon <= f1_lon + pa[47:16] + {pb[15:0], 16'd0};
      f2_re2 <= eq_radius * eq_radius;

      r2     <= sx + sy + sz;
      f3_lat <= f2_lat;
      f3_lon <= f2_lon;
      f3_re2 <= f2_re2;
    end
  end

  always_comb begin
    ch[0].lat   = rot_init(f3_lat);
    ch[0].lon   = rot_init(f3_lon);
    ch[0].r2    = r2;
    ch[0].num_t = {grav_parameter, 16'd0};
    ch[0].num_e = {f3_re2, 32'd0};
    ch[0].rem_t = {60'd0, grav_parameter[49:46]};
    ch[0].rem_e = {46'd0, f3_re2[47:30]};
    ch[0].quo_t = 62'd0;
    ch[0].quo_e = 62'd0;
    // quotient would not fit in 62 bits: limit applies
    ch[0].sat_t = {60'd0, grav_parameter[49:46]} >= r2;
    ch[0].sat_e = {46'd0, f3_re2[47:30]} >= r2;
    ch[0].zero  = (r2 == 64'd0);
    chv[0]      = f3_v;
  end

  for (genvar g = 0; g < CellCount; g++) begin : g_cell
    j2g_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .stage     (6'(g)),
      .valid_in  (chv[g]),
      .d         (ch[g]),
      .valid_out (chv[g+1]),
      .q         (ch[g+1])
    );
  end

  j2g_post u_post (
    .clk            (clk),
    .rst            (rst),
    .en             (en),
    .valid_in       (chv[CellCount]),
    .d              (ch[CellCount]),
    .j2_coefficient (j2_coefficient),
    .valid_out      (out_v),
    .grav_x         (out_ch.grav_x),
    .grav_y         (out_ch.grav_y),
    .grav_z         (out_ch.grav_z)
  );

  assign out_ch.valid = out_v;

endmodule

/* verif/tb_j2_gravity_vector_core.sv */
// self-checking testbench for j2_gravity_vector_core: random and directed positions, angles,
// and times with random stalls on both channels, checked against an in-bench gravity predictor
// depends on j2g_pkg, j2g_in_if, j2g_out_if and the core itself
module tb_j2_gravity_vector_core;
  import j2g_pkg::*;

  typedef struct {
    logic signed [31:0] px, py, pz, lat, lon;
    logic [47:0]        t;
  } sample_t;

  typedef struct {
    logic signed [31:0] gx, gy, gz;
  } gvec_t;

  localparam longint unsigned CapQ = 64'h2000_0000_0000_0000;
  localparam longint OneQ = 64'sd1073741824;
  localparam logic [31:0] DefRate = 32'd49846;
  localparam logic [49:0] DefMu = 50'd398600441800000;
  localparam logic [23:0] DefRe = 24'd6378137;
  localparam logic [23:0] DefJ2 = 24'd4649860;

  logic clk, rst;
  logic psel, penable, pwrite;
  logic [4:0] paddr;
  logic [63:0] pwdata, prdata;
  logic pready;

  j2g_in_if in_ch();
  j2g_out_if out_ch();

  j2_gravity_vector_core dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // predictor copy of the registers
  logic [31:0] m_rate;
  logic [49:0] m_mu;
  logic [23:0] m_re, m_j2;

  sample_t pending_q[$];
  gvec_t   gravity_q[$];
  int errors = 0;
  int n_in = 0, n_out = 0;
  bit no_idle = 0;
  // input transfer seen at the last rising edge
  bit in_acc = 0;

  // (a*b) >> sh truncated toward zero, magnitude capped at 2^61
  function automatic longint prod_shift(longint a, longint b, int sh);
    logic [63:0] ua, ub, r;
    logic [127:0] p, q;
    ua = (a < 0) ? 64'(-a) : 64'(a);
    ub = (b < 0) ? 64'(-b) : 64'(b);
    p = ua * ub;
    q = p >> sh;
    if (q[127:64] != 0) r = CapQ;
    else r = q[63:0];
    if (r > CapQ) r = CapQ;
    return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint frac_quot(logic [63:0] num, logic [63:0] den, int fb);
    logic [127:0] q;
    q = ({64'd0, num} << fb) / {64'd0, den};
    return (q > CapQ) ? longint'(CapQ) : longint'(q[63:0]);
  endfunction

  function automatic void cordic_sincos(logic [31:0] ang, output longint s, output longint c);
    logic flip;
    logic [31:0] u;
    longint x, y, z, dx, dy;
    flip = ang[31] ^ ang[30];
    u = flip ? ang + 32'h8000_0000 : ang;
    z = longint'($signed(u));
    x = 652032874;
    y = 0;
    for (int i = 0; i < 32; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(AtanTab[i]);
      end else begin
        x += dx; y -= dy; z += longint'(AtanTab[i]);
      end
    end
    s = flip ? -y : y;
    c = flip ? -x : x;
  endfunction

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fff_ffff;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic gvec_t gravity_vector(sample_t it);
    gvec_t g;
    logic [63:0] ax, ay, az, r2;
    logic [79:0] ph;
    logic [31:0] lon;
    longint s, c, so, co, tq, eq, pq, sc, s2, nq, dq, gn, gd;
    ax = (it.px < 0) ? 64'(-longint'(it.px)) : 64'(longint'(it.px));
    ay = (it.py < 0) ? 64'(-longint'(it.py)) : 64'(longint'(it.py));
    az = (it.pz < 0) ? 64'(-longint'(it.pz)) : 64'(longint'(it.pz));
    r2 = ax * ax + ay * ay + az * az;
    g.gx = 0; g.gy = 0; g.gz = 0;
    if (r2 == 0) return g;
    ph = {48'd0, m_rate} * {32'd0, it.t};
    lon = it.lon + ph[47:16];
    cordic_sincos(it.lat, s, c);
    cordic_sincos(lon, so, co);
    tq = frac_quot({14'd0, m_mu}, r2, 16);
    eq = frac_quot(64'(m_re) * 64'(m_re), r2, 32);
    pq = prod_shift(longint'(m_j2), eq, 32);
    sc = prod_shift(s, c, 30);
    s2 = prod_shift(s, s, 30);
    nq = prod_shift(-3 * sc, pq, 32);
    dq = OneQ + prod_shift(3 * (OneQ - 3 * s2), pq, 33);
    gn = prod_shift(tq, nq, 30);
    gd = prod_shift(tq, dq, 30);
    g.gx = clamp32(prod_shift(gn, c, 30) - prod_shift(gd, s, 30));
    g.gy = clamp32(-prod_shift(prod_shift(gn, so, 30), s, 30)
                   - prod_shift(prod_shift(gd, so, 30), c, 30));
    g.gz = clamp32(prod_shift(prod_shift(gn, co, 30), s, 30)
                   + prod_shift(prod_shift(gd, co, 30), c, 30));
    return g;
  endfunction

  initial begin
    clk = 0;
    rst = 1;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    in_ch.valid = 0; in_ch.pos_x = 0; in_ch.pos_y = 0; in_ch.pos_z = 0;
    in_ch.latitude = 0; in_ch.longitude = 0; in_ch.sim_time = 0;
    out_ch.ready = 0;
    forever #5 clk = ~clk;
  end

  // input driver
  always @(negedge clk) begin
    if (!rst && (!in_ch.valid || in_acc)) begin
      if (pending_q.size() != 0 && (no_idle || $urandom_range(99) >= 36)) begin
        sample_t it;
        it = pending_q.pop_front();
        in_ch.pos_x <= it.px; in_ch.pos_y <= it.py; in_ch.pos_z <= it.pz;
        in_ch.latitude <= it.lat; in_ch.longitude <= it.lon; in_ch.sim_time <= it.t;
        in_ch.valid <= 1;
      end else begin
        in_ch.valid <= 0;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst) out_ch.ready <= no_idle || ($urandom_range(99) >= 36);
  end

  // expectation on each input transfer, compare on each output transfer
  always @(posedge clk) begin
    in_acc = !rst && in_ch.valid && in_ch.ready;
    if (in_acc) begin
      sample_t it;
      it.px = in_ch.pos_x; it.py = in_ch.pos_y; it.pz = in_ch.pos_z;
      it.lat = in_ch.latitude; it.lon = in_ch.longitude; it.t = in_ch.sim_time;
      gravity_q.push_back(gravity_vector(it));
      n_in++;
    end
    if (!rst && out_ch.valid && out_ch.ready) begin
      n_out++;
      if (gravity_q.size() == 0) begin
        $display("%0t: unexpected result x=%0d y=%0d z=%0d", $time,
                 out_ch.grav_x, out_ch.grav_y, out_ch.grav_z);
        errors++;
      end else begin
        gvec_t e;
        e = gravity_q.pop_front();
        if (e.gx !== out_ch.grav_x || e.gy !== out_ch.grav_y || e.gz !== out_ch.grav_z) begin
          $display("%0t: gravity mismatch expected x=%0d y=%0d z=%0d actual x=%0d y=%0d z=%0d",
                   $time, e.gx, e.gy, e.gz, out_ch.grav_x, out_ch.grav_y, out_ch.grav_z);
          errors++;
        end
      end
    end
  end

  task automatic reg_write(reg_idx_t idx, logic [63:0] val);
    @(negedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= 5'(int'(idx) * 8); pwdata <= val;
    @(negedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (idx)
      REG_EARTH_RATE: m_rate = val[31:0];
      REG_GRAV_PARAM: m_mu = val[49:0];
      REG_EQ_RADIUS:  m_re = val[23:0];
      REG_J2_COEF:    m_j2 = val[23:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(logic [31:0] r, logic [49:0] mu, logic [23:0] re, logic [23:0] j2);
    reg_write(REG_EARTH_RATE, 64'(r));
    reg_write(REG_GRAV_PARAM, 64'(mu));
    reg_write(REG_EQ_RADIUS, 64'(re));
    reg_write(REG_J2_COEF, 64'(j2));
  endtask

  task automatic add_sample(int px, int py, int pz, int lat, int lon, logic [47:0] t);
    sample_t it;
    it.px = px; it.py = py; it.pz = pz; it.lat = lat; it.lon = lon; it.t = t;
    pending_q.push_back(it);
  endtask

  task automatic drain();
    while (pending_q.size() != 0 || gravity_q.size() != 0 || in_ch.valid) @(posedge clk);
    repeat (90) @(posedge clk);
  endtask

  // mostly orbit-like positions, some full-range noise
  task automatic add_random(int n);
    int lo, hi;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(3) != 0) begin
        lo = $urandom_range(1) ? 6_300_000 : 1000;
        hi = 42_200_000;
        add_sample(($urandom_range(1) ? 1 : -1) * int'($urandom_range(hi, 0)),
                   ($urandom_range(1) ? 1 : -1) * int'($urandom_range(hi, 0)),
                   ($urandom_range(1) ? 1 : -1) * int'($urandom_range(hi, lo)),
                   $urandom, $urandom, {16'($urandom_range(16'hffff)), $urandom});
      end else begin
        add_sample($urandom, $urandom, $urandom, $urandom, $urandom,
                   {16'($urandom), $urandom});
      end
    end
  endtask

  initial begin
    m_rate = DefRate; m_mu = DefMu; m_re = DefRe; m_j2 = DefJ2;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed: origin, tiny radius, extreme positions, pole and half-turn angles
    add_sample(0, 0, 0, 32'h4000_0000, 0, 0);
    add_sample(1, 0, 0, 0, 0, 0);
    add_sample(0, 0, -1, 32'h4000_0000, 32'h8000_0000, 0);
    add_sample(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
               32'h7fff_ffff, 48'hffff_ffff_ffff);
    add_sample(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
               32'h8000_0000, 48'hffff_ffff_ffff);
    add_sample(6_378_137, 0, 0, 0, 0, 0);
    add_sample(0, 6_378_137, 0, 0, 32'h4000_0000, 48'h1_0000);
    add_sample(0, 0, 6_356_752, 32'h4000_0000, 0, 48'h5460_0000);
    add_sample(0, 0, -6_356_752, 32'hc000_0000, 0, 48'h0000_ffff_ffff);
    add_sample(4_000_000, -4_000_000, 3_000_000, 32'h2000_0000, 32'he000_0000, 48'h1234_5678);
    add_sample(-42_164_000, 0, 0, 32'h3fff_ffff, 32'hc000_0001, 48'h8000_0000_0000);
    add_sample(1000, -1000, 10, 32'hbfff_ffff, 32'h4000_0001, 48'h7fff_ffff_ffff);
    add_sample(-6_500_000, 1, -1, 32'h0000_0001, 32'hffff_ffff, 48'h1);
    add_random(200);
    drain();

    set_regs(32'hffff_ffff, 50'h3_ffff_ffff_ffff, 24'hff_ffff, 24'hff_ffff);
    add_sample(1, 0, 0, 32'h2000_0000, 0, 48'hffff_ffff_ffff);
    add_sample(7_000_000, 0, 0, 32'h1000_0000, 0, 48'hffff_ffff_ffff);
    add_random(200);
    drain();

    set_regs(32'd0, 50'd0, 24'd0, 24'd0);
    add_random(150);
    drain();

    set_regs($urandom, {18'($urandom), $urandom}, 24'($urandom), 24'($urandom));
    add_random(200);
    drain();

    // back to defaults, no idling on either side
    set_regs(DefRate, DefMu, DefRe, DefJ2);
    no_idle = 1;
    add_random(150);
    drain();
    no_idle = 0;
    add_random(100);
    drain();

    $display("covered %0d inputs and %0d results over five register settings", n_in, n_out);
    $display("including zero, extreme and default constants and stall-free stretches");
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end
endmodule

/* files.f */
hdl/j2g_pkg.sv
hdl/j2g_in_if.sv
hdl/j2g_out_if.sv
hdl/j2g_cell.sv
hdl/j2g_mulsh.sv
hdl/j2g_post.sv
hdl/j2_gravity_vector_core.sv
verif/tb_j2_gravity_vector_core.sv
